/* src/nac_pkg.sv */
// ----------------------------------------------------------------------------
// Named counter table package
// Shared types, codes and sizes for the named atomic counter table.
// ----------------------------------------------------------------------------
package nac_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = $clog2(ENTRIES > 1 ? ENTRIES : 2);
  // The queue depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_FETCH   = 2'd0;
  localparam logic [1:0] OP_SET     = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    K_REPLY,
    K_FETCH,
    K_SET
  } nac_kind_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        key;
    logic               create_if_missing;
    logic signed [63:0] pre_increment;
    logic signed [63:0] post_increment;
    logic signed [63:0] new_value;
    logic               check_old;
    logic signed [63:0] expected_value;
  } nac_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] value;
    logic               created;
  } nac_out_t;

  typedef struct packed {
    nac_kind_t          kind;
    logic [1:0]         status;
    logic [IDX_W-1:0]   idx;
    logic               created;
    logic signed [63:0] pre_increment;
    logic signed [63:0] post_increment;
    logic signed [63:0] new_value;
    logic               check_old;
    logic signed [63:0] expected_value;
  } nac_cmd_t;

endpackage

/* src/nac_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module nac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* src/nac_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO that decouples the lookup front end from the counter back end.
// ----------------------------------------------------------------------------
module nac_queue
  import nac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  nac_cmd_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output nac_cmd_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  nac_cmd_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/nac_front.sv */
// ----------------------------------------------------------------------------
// Counter table front end
// Accepts requests, matches keys against the name table, allocates and frees
// entries, and queues a command for the back end.
// ----------------------------------------------------------------------------
module nac_front
  import nac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  nac_in_t  in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     q_push,
  output nac_cmd_t q_data
);

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]        key_r [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic               hit, any_free, alloc;
  logic [IDX_W-1:0]   hit_idx, free_idx;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    hit      = 1'b0;
    any_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (key_r[i] == in_data.key);
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    alloc                 = 1'b0;
    valid_nxt             = valid_r;
    q_data.kind           = K_REPLY;
    q_data.status         = ST_NOTFOUND;
    q_data.idx            = hit_idx;
    q_data.created        = 1'b0;
    q_data.pre_increment  = in_data.pre_increment;
    q_data.post_increment = in_data.post_increment;
    q_data.new_value      = in_data.new_value;
    q_data.check_old      = in_data.check_old;
    q_data.expected_value = in_data.expected_value;
    unique case (in_data.op)
      OP_FETCH: begin
        if (hit) begin
          q_data.kind = K_FETCH;
        end else if (in_data.create_if_missing) begin
          if (any_free) begin
            alloc          = 1'b1;
            q_data.kind    = K_FETCH;
            q_data.idx     = free_idx;
            q_data.created = 1'b1;
          end else begin
            q_data.status = ST_FULL;
          end
        end
      end
      OP_SET: begin
        if (hit) begin
          q_data.kind = K_SET;
        end
      end
      OP_DESTROY: begin
        if (hit) begin
          q_data.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    if (q_push && alloc) begin
      valid_nxt[free_idx] = 1'b1;
    end
    if (q_push && in_data.op == OP_DESTROY && hit) begin
      valid_nxt[hit_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (q_push && alloc) begin
      key_r[free_idx] <= in_data.key;
    end
  end

  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one valid entry holds the same key");

  a_alloc_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && alloc) |=> valid_r[$past(free_idx)])
    else $error("allocated entry not marked valid");

endmodule

/* src/nac_back.sv */
// ----------------------------------------------------------------------------
// Counter table back end
// Reads the counter store, applies add or set, writes back and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module nac_back
  import nac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_not_empty,
  input  nac_cmd_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  output nac_out_t out_data,
  input  logic     out_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t             state_r;
  nac_cmd_t           cmd_r;
  logic signed [63:0] acc_r;
  logic               mismatch_r;
  logic               out_valid_r;
  nac_out_t           out_data_r;

  logic               out_free;
  logic               ram_rd_en, ram_wr_en;
  logic [63:0]        ram_rd_data, ram_wr_data;
  logic signed [63:0] base;
  nac_out_t           res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == S_IDLE) && q_not_empty;
  assign ram_rd_en = q_pop && (q_head.kind != K_REPLY);
  assign base      = cmd_r.created ? 64'sd0 : $signed(ram_rd_data);

  always_comb begin
    res.status  = cmd_r.status;
    res.value   = 64'sd0;
    res.created = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_data = acc_r + cmd_r.post_increment;
    case (cmd_r.kind)
      K_FETCH: begin
        res.status  = ST_OK;
        res.value   = acc_r;
        res.created = cmd_r.created;
        ram_wr_en   = 1'b1;
      end
      K_SET: begin
        ram_wr_data = cmd_r.new_value;
        if (mismatch_r) begin
          res.status = ST_MISMATCH;
        end else begin
          res.status = ST_OK;
          res.value  = cmd_r.new_value;
          ram_wr_en  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!(state_r == S_DONE && out_free)) begin
      ram_wr_en = 1'b0;
    end
  end

  nac_ram #(
    .WIDTH(64),
    .DEPTH(ENTRIES)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cmd_r.idx),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (q_head.idx),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            cmd_r   <= q_head;
            state_r <= (q_head.kind == K_REPLY) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          acc_r      <= base + cmd_r.pre_increment;
          mismatch_r <= cmd_r.check_old && (base != cmd_r.expected_value);
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r <= res;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat loaded outside the completion state");

  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |=> state_r == S_IDLE)
    else $error("counter written without completing the command");

  a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.created) |-> out_data_r.status == ST_OK)
    else $error("created flag set on a failed request");

endmodule

/* src/named_atomic_counter_table.sv */
// ----------------------------------------------------------------------------
// Named atomic counter table
// Associative table of signed 64-bit counters named by 32-bit keys, with
// fetch-and-add, conditional set and destroy.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Beat
// in_       input      in_valid/in_stall   nac_in_t request
// out_      output     out_valid/out_stall nac_out_t result
//
// The front end matches the key and updates the name table in the accept
// cycle, then queues a command. The back end takes a fetch or set through its
// idle (counter RAM read), read (add or compare) and done (write-back) states,
// and the rest through idle and done, one command at a time. Reset clears all
// entries at once, with no clearing pass. The front end keeps taking requests
// while the queue has room, even while a result beat waits under out_stall.
// ----------------------------------------------------------------------------
module named_atomic_counter_table
  import nac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  nac_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  output nac_out_t out_data,
  input  logic     out_stall
);

  logic     q_push, q_pop, q_full, q_not_empty;
  nac_cmd_t q_in, q_head;

  nac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  nac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  nac_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule

/* verif/nac_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Named counter table checker
// Watches both channels of the counter table. Every accepted request beat is
// run through a behavioural copy of the table, which queues the expected
// result. Every accepted result beat is compared field by field with the
// oldest queued expectation, and each difference is counted and reported.
// ----------------------------------------------------------------------------
module nac_checker
  import nac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  nac_in_t  in_data,
  input  logic     in_stall,
  input  logic     out_valid,
  input  nac_out_t out_data,
  input  logic     out_stall,
  output int       mismatches,
  output int       awaiting,
  output int       checked,
  output int       allocations,
  output int       full_hits,
  output int       compare_fails
);

  logic        live   [ENTRIES];
  logic [31:0] names  [ENTRIES];
  logic [63:0] counts [ENTRIES];
  nac_out_t    replies_due [$];

  function automatic nac_out_t apply_request(input nac_in_t rq);
    nac_out_t r;
    int       hit;
    int       slot;
    r.status  = ST_NOTFOUND;
    r.value   = '0;
    r.created = 1'b0;
    hit       = -1;
    slot      = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (live[i] && names[i] == rq.key) hit = i;
      if (!live[i]) slot = i;
    end
    case (rq.op)
      OP_FETCH: begin
        if (hit < 0 && rq.create_if_missing) begin
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            live[slot]   = 1'b1;
            names[slot]  = rq.key;
            counts[slot] = '0;
            r.created    = 1'b1;
            hit          = slot;
          end
        end
        if (hit >= 0) begin
          counts[hit] = counts[hit] + rq.pre_increment;
          r.value     = counts[hit];
          counts[hit] = counts[hit] + rq.post_increment;
          r.status    = ST_OK;
        end
      end
      OP_SET: begin
        if (hit >= 0) begin
          if (rq.check_old && counts[hit] != rq.expected_value) begin
            r.status = ST_MISMATCH;
          end else begin
            counts[hit] = rq.new_value;
            r.value     = rq.new_value;
            r.status    = ST_OK;
          end
        end
      end
      OP_DESTROY: begin
        if (hit >= 0) begin
          live[hit] = 1'b0;
          r.status  = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, $signed(exp_v),
               $signed(act_v));
    end
  endtask

  always @(posedge clk) begin : watch
    nac_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        live[i]   = 1'b0;
        names[i]  = '0;
        counts[i] = '0;
      end
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat expected none, got status %0d value %0d",
                   $time, out_data.status, $signed(out_data.value));
        end else begin
          want = replies_due.pop_front();
          checked++;
          if (want.created) allocations++;
          if (want.status == ST_FULL) full_hits++;
          if (want.status == ST_MISMATCH) compare_fails++;
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("value", want.value, out_data.value);
          check_field("created", 64'(want.created), 64'(out_data.created));
        end
      end
      if (in_valid && !in_stall) replies_due.push_back(apply_request(in_data));
    end
    awaiting = replies_due.size();
  end

endmodule

/* verif/tb_named_atomic_counter_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Named atomic counter table testbench
// Drives a short directed sequence covering wrap-around, compare-and-set,
// misses, destroy, the unused opcode and a full table, then several hundred
// random requests over a small pool of keys in bursts, against a receiver
// that stalls on its own pattern and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_named_atomic_counter_table;
  import nac_pkg::*;

  localparam logic [1:0]         OP_UNUSED    = 2'd3;
  localparam logic signed [63:0] MAX64        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64        = 64'sh8000_0000_0000_0000;
  localparam int                 POOL         = 24;
  localparam int                 RANDOM_ITEMS = 650;
  localparam int                 HOLD_AFTER   = 300;
  localparam int                 HOLD_CYCLES  = 300;
  localparam int                 DRAIN_CYCLES = 20;
  localparam int                 CYCLE_LIMIT  = 200000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  nac_in_t  in_data;
  logic     in_stall;
  logic     out_valid;
  nac_out_t out_data;
  logic     out_stall;

  int mismatches;
  int awaiting;
  int checked;
  int allocations;
  int full_hits;
  int compare_fails;
  int beats_sent = 0;
  int cycles     = 0;

  logic [31:0] key_pool [POOL];

  always #1 clk = ~clk;

  named_atomic_counter_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  nac_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .checked       (checked),
    .allocations   (allocations),
    .full_hits     (full_hits),
    .compare_fails (compare_fails)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               awaiting);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic nac_in_t request(input logic [1:0] op, input logic [31:0] key,
                                      input logic create,
                                      input logic signed [63:0] pre,
                                      input logic signed [63:0] post,
                                      input logic signed [63:0] nv, input logic chk,
                                      input logic signed [63:0] expv);
    nac_in_t rq;
    rq.op                = op;
    rq.key               = key;
    rq.create_if_missing = create;
    rq.pre_increment     = pre;
    rq.post_increment    = post;
    rq.new_value         = nv;
    rq.check_old         = chk;
    rq.expected_value    = expv;
    return rq;
  endfunction

  function automatic logic signed [63:0] pick_value();
    logic signed [63:0] v;
    case ($urandom_range(9))
      0: v = MAX64;
      1: v = MIN64;
      2: v = '0;
      3, 4: v = {$urandom, $urandom};
      default: begin
        v = $signed(64'($urandom_range(6))) - 64'sd3;
      end
    endcase
    return v;
  endfunction

  function automatic nac_in_t random_request();
    logic [1:0]  op;
    logic [31:0] key;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 45) op = OP_FETCH;
    else if (roll < 72) op = OP_SET;
    else if (roll < 94) op = OP_DESTROY;
    else op = OP_UNUSED;
    key = ($urandom_range(15) == 0) ? 32'($urandom) : key_pool[$urandom_range(POOL - 1)];
    return request(op, key, $urandom_range(9) < 7, pick_value(), pick_value(),
                   pick_value(), 1'($urandom_range(1)), pick_value());
  endfunction

  task automatic send(input nac_in_t rq);
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin : receiver
    int span;
    int mode;
    bit held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      span = $urandom_range(10, 80);
      mode = $urandom_range(3);
      repeat (span) begin
        if (!held_off && beats_sent >= HOLD_AFTER) begin
          held_off = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3) == 0);
            2: out_stall <= ($urandom_range(3) != 0);
            default: out_stall <= 1'($urandom_range(1));
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int burst;
    int n;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(request(OP_FETCH, key_pool[0], 1'b0, 64'sd5, 64'sd5, '0, 1'b0, '0));
    send(request(OP_FETCH, key_pool[0], 1'b1, MAX64, MAX64, '0, 1'b0, '0));
    send(request(OP_FETCH, key_pool[0], 1'b0, 64'sd2, -64'sd1, MAX64, 1'b1, MIN64));
    send(request(OP_SET, key_pool[0], 1'b1, MAX64, MAX64, MAX64, 1'b1, '0));
    send(request(OP_SET, key_pool[0], 1'b0, '0, '0, MIN64, 1'b1, -64'sd1));
    send(request(OP_FETCH, key_pool[0], 1'b0, -64'sd1, '0, '0, 1'b0, '0));
    send(request(OP_UNUSED, key_pool[0], 1'b1, '1, '1, '1, 1'b1, '1));
    send(request(OP_DESTROY, key_pool[0], 1'b1, MIN64, MIN64, MIN64, 1'b1, MIN64));
    send(request(OP_DESTROY, key_pool[0], 1'b0, '0, '0, '0, 1'b0, '0));
    send(request(OP_SET, key_pool[0], 1'b0, '0, '0, MAX64, 1'b0, '0));
    for (int i = 0; i < ENTRIES; i++)
      send(request(OP_FETCH, key_pool[i], 1'b1, 64'(i), 64'(-i), '0, 1'b0, '0));
    send(request(OP_FETCH, key_pool[ENTRIES], 1'b1, MAX64, MAX64, '0, 1'b0, '0));

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
        send(random_request());
        n++;
      end
      idle(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d request beats and %0d checked result beats.", beats_sent,
             checked);
    $display("Seen: %0d allocations, %0d table-full replies, %0d failed conditional sets.",
             allocations, full_hits, compare_fails);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
